>>> design/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg - shared definitions for the 3x3 Laplacian sharpening filter
//
// Frame limits, field widths, configuration register indexes, stream command
// codes and the geometry clamp used when the frame size is written.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 2048;
    localparam int GAIN_FRAC_BITS = 8;

    // Field widths fixed by the stream and register definitions
    localparam int CHAN_W     = 8;
    localparam int GAIN_W     = 10;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // Column address into the line stores
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Holds a frame dimension plus one (drain count, row position past the end)
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 2);

    // Arithmetic widths
    localparam int LAP_W  = CHAN_W + 3;
    localparam int PROD_W = LAP_W + GAIN_W;
    localparam int CTR_W  = CHAN_W + GAIN_FRAC_BITS + 1;
    localparam int V_W    = ((PROD_W > CTR_W) ? PROD_W : CTR_W) + 1;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_GAIN   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // Packed pixel, lane 0 blue, lane 1 green, lane 2 red
    typedef logic [2:0][CHAN_W-1:0] t_px;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                   input int unsigned lim);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > int'(lim)) begin
            res = DIM_W'(lim);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

>>> design/lsh_pix_if.sv
// ----------------------------------------------------------------------------
// lsh_pix_if - input pixel channel
//
// Valid/ready channel carrying one raster pixel or a drain tick per
// transaction.
// ----------------------------------------------------------------------------
interface lsh_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [lsh_pkg::CHAN_W-1:0]   in_blue;
    logic [lsh_pkg::CHAN_W-1:0]   in_green;
    logic [lsh_pkg::CHAN_W-1:0]   in_red;

    modport source (output valid, output cmd, output in_blue, output in_green,
                    output in_red, input ready);
    modport sink   (input valid, input cmd, input in_blue, input in_green,
                    input in_red, output ready);
endinterface

>>> design/lsh_res_if.sv
// ----------------------------------------------------------------------------
// lsh_res_if - sharpened pixel channel
//
// Valid/ready channel carrying one sharpened pixel with its row and frame
// end markers per transaction.
// ----------------------------------------------------------------------------
interface lsh_res_if;
    logic                         valid;
    logic                         ready;
    logic [lsh_pkg::CHAN_W-1:0]   out_blue;
    logic [lsh_pkg::CHAN_W-1:0]   out_green;
    logic [lsh_pkg::CHAN_W-1:0]   out_red;
    logic                         row_end;
    logic                         frame_end;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input row_end, input frame_end, output ready);
endinterface

>>> design/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3 - streaming 3x3 Laplacian sharpening of BGR pixels
//
// Pixels enter on i_pix in raster order, one transaction each; cmd marks a
// drain tick, which carries no pixel. After the last pixel of a frame send
// image_width+1 drain ticks to flush the last row. Sharpened pixels leave on
// o_res with row_end and frame_end markers. Each output pixel needs its
// lower neighbour, so a result follows the input by one row plus one pixel;
// the first image_width+1 pixels of a frame give no result.
// Throughput is one transaction per clock while i_pix.ready is high: each
// line store has one read port and one write port, used once per pixel
// (read at acceptance, written back in the next cycle, with forwarding when
// consecutive pixels share a column). A result reaches o_res through line
// store read, window select and Laplacian, gain multiply, then rounding
// into an 8-entry result queue.
// When o_res stalls the queue fills; i_pix.ready drops once the queue plus
// the results in flight would fill it, and comes straight back as it drains.
// Reset (i_rst_n low, synchronous) empties the pipeline and queue, restores
// 640x480 and gain 1.0. The line stores need no clearing pass: entries not
// yet written only stand in for rows outside the frame.
// Writing image_width or image_height restarts the frame.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lsh_pix_if.sink                          i_pix,
    lsh_res_if.source                        o_res,
    input  logic                             i_cfg_wr_en,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int F      = lsh_pkg::GAIN_FRAC_BITS;
    localparam int V_W    = lsh_pkg::V_W;
    localparam int Q_W    = V_W - F;
    localparam int QR_W   = Q_W + 1;
    localparam int CHAN_W = lsh_pkg::CHAN_W;
    localparam int LAP_W  = lsh_pkg::LAP_W;
    localparam int DIM_W  = lsh_pkg::DIM_W;
    localparam int COL_W  = lsh_pkg::COL_W;
    localparam int CNT_W  = lsh_pkg::CNT_W;
    localparam int PTR_W  = lsh_pkg::PTR_W;
    localparam int CHAN_MAX = (1 << CHAN_W) - 1;

    typedef struct packed {
        logic emit;
        logic top;
        logic bot;
        logic lf_self;
        logic rt_self;
        logic row_end;
        logic frame_end;
    } t_emit_ctl;

    typedef struct packed {
        lsh_pkg::t_px px;
        logic         row_end;
        logic         frame_end;
    } t_res;

    function automatic logic [CHAN_W-1:0] round_sat(input logic signed [V_W-1:0] v);
        logic [Q_W-1:0]    q;
        logic [F-1:0]      rem;
        logic [F-1:0]      half;
        logic              inc;
        logic [QR_W-1:0]   qr;
        logic [CHAN_W-1:0] res;
        q    = v[V_W-1:F];
        rem  = v[F-1:0];
        half = F'(1) << (F - 1);
        inc  = (rem > half) || ((rem == half) && q[0]);
        qr   = {1'b0, q} + QR_W'(inc);
        if (v[V_W-1] || (v == '0)) begin
            res = '0;
        end else if (qr > QR_W'(CHAN_MAX)) begin
            res = CHAN_W'(CHAN_MAX);
        end else begin
            res = qr[CHAN_W-1:0];
        end
        return res;
    endfunction

    // Configuration and frame position
    logic [DIM_W-1:0]          r_w, r_h;
    logic [lsh_pkg::GAIN_W-1:0] r_gain;
    logic [COL_W-1:0]          r_col, n_col;
    logic [DIM_W-1:0]          r_row, n_row;
    logic [DIM_W-1:0]          r_drain, n_drain;

    // Front end
    logic                      pix_acc, mem_go, mem_go_acc, restart, eor;
    logic [DIM_W-1:0]          d_idx, cur_r;
    logic [COL_W-1:0]          cur_c;
    lsh_pkg::t_px              px_in;
    logic                      emit_first, emit_second;
    t_emit_ctl                 ctl;

    // Line stores and their read/forward registers
    lsh_pkg::t_px              r_line_above [lsh_pkg::MAX_WIDTH];
    lsh_pkg::t_px              r_line_mid   [lsh_pkg::MAX_WIDTH];
    lsh_pkg::t_px              r_rd_above, r_rd_mid;
    logic                      r_fwd;
    lsh_pkg::t_px              r_fwd_a, r_fwd_m;

    // Stage 1: write back, window, select
    logic                      r_s1_vld;
    logic [COL_W-1:0]          r_s1_addr;
    lsh_pkg::t_px              r_s1_px;
    t_emit_ctl                 r_s1_ctl;
    lsh_pkg::t_px              s1_a, s1_m;
    lsh_pkg::t_px              r_win_top, r_win_mid1, r_win_mid2, r_win_bot;
    lsh_pkg::t_px              sel_c, sel_u, sel_d, sel_l, sel_r;
    logic signed [LAP_W-1:0]   lap [3];

    // Stage 2: multiply
    logic                      r_s2_vld;
    lsh_pkg::t_px              r_s2_ctr;
    logic signed [LAP_W-1:0]   r_s2_lap [3];
    logic                      r_s2_rend, r_s2_fend;
    logic signed [V_W-1:0]     prod [3];

    // Stage 3: round into the queue
    logic                      r_s3_vld;
    logic signed [V_W-1:0]     r_s3_v [3];
    logic                      r_s3_rend, r_s3_fend;
    t_res                      res_in;

    // Result queue
    t_res                      r_fifo [lsh_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]          r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          committed;
    logic                      pop;
    t_res                      head;

    // ------------------------------------------------------------------
    // Position of the accepted transaction and what it emits
    // ------------------------------------------------------------------
    assign pix_acc    = i_pix.valid && i_pix.ready;
    assign mem_go_acc = pix_acc && mem_go;
    assign d_idx      = r_w + DIM_W'(1) - r_drain;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        cur_c   = '0;
        cur_r   = '0;
        mem_go  = 1'b0;
        px_in   = '0;
        restart = (DIM_W'(r_col) >= r_w) || (r_row >= r_h);
        eor     = 1'b0;
        if (i_pix.cmd == lsh_pkg::CMD_PIXEL) begin
            cur_c   = restart ? '0 : r_col;
            cur_r   = restart ? '0 : r_row;
            mem_go  = 1'b1;
            px_in   = {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
            n_drain = '0;
            eor     = (DIM_W'(cur_c) == r_w - DIM_W'(1));
            if (eor) begin
                n_col = '0;
                if (cur_r == r_h - DIM_W'(1)) begin
                    n_row   = '0;
                    n_drain = r_w + DIM_W'(1);
                end else begin
                    n_row = cur_r + DIM_W'(1);
                end
            end else begin
                n_col = cur_c + COL_W'(1);
            end
        end else if ((r_drain != '0) && (r_drain <= r_w + DIM_W'(1))) begin
            mem_go  = 1'b1;
            n_drain = r_drain - DIM_W'(1);
            if (d_idx < r_w) begin
                cur_r = r_h;
                cur_c = d_idx[COL_W-1:0];
            end else begin
                cur_r = r_h + DIM_W'(1);
                cur_c = '0;
            end
        end else begin
            // nothing owed: drop the tick
            n_drain = '0;
        end
    end

    always_comb begin
        emit_first  = (cur_c == '0) && (cur_r >= DIM_W'(2));
        emit_second = (cur_c != '0) && (cur_r != '0);
        ctl.emit    = emit_first || emit_second;
        ctl.top     = emit_first ? (cur_r == DIM_W'(2)) : (cur_r == DIM_W'(1));
        ctl.bot     = emit_first ? (cur_r == r_h + DIM_W'(1)) : (cur_r == r_h);
        ctl.lf_self = emit_first ? (r_w == DIM_W'(1)) : (cur_c == COL_W'(1));
        ctl.rt_self = emit_first;
        ctl.row_end = emit_first;
        ctl.frame_end = emit_first && (cur_r == r_h + DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= DIM_W'(640);
            r_h     <= DIM_W'(480);
            r_gain  <= lsh_pkg::GAIN_W'(256);
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lsh_pkg::CFG_WIDTH: begin
                    r_w     <= lsh_pkg::clamp_dim(i_cfg_data, lsh_pkg::MAX_WIDTH);
                    r_col   <= '0;
                    r_row   <= '0;
                    r_drain <= '0;
                end
                lsh_pkg::CFG_HEIGHT: begin
                    r_h     <= lsh_pkg::clamp_dim(i_cfg_data, lsh_pkg::MAX_HEIGHT);
                    r_col   <= '0;
                    r_row   <= '0;
                    r_drain <= '0;
                end
                lsh_pkg::CFG_GAIN: begin
                    r_gain <= i_cfg_data[lsh_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (pix_acc) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read at acceptance, write back from stage 1
    // ------------------------------------------------------------------
    assign s1_a = r_fwd ? r_fwd_a : r_rd_above;
    assign s1_m = r_fwd ? r_fwd_m : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (mem_go_acc) begin
            r_rd_above <= r_line_above[cur_c];
        end
        if (r_s1_vld) begin
            r_line_above[r_s1_addr] <= s1_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_go_acc) begin
            r_rd_mid <= r_line_mid[cur_c];
        end
        if (r_s1_vld) begin
            r_line_mid[r_s1_addr] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= mem_go_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_go_acc) begin
            r_s1_addr <= cur_c;
            r_s1_px   <= px_in;
            r_s1_ctl  <= ctl;
            // same column written back this cycle: take the new values
            r_fwd     <= r_s1_vld && (r_s1_addr == cur_c);
            r_fwd_a   <= s1_m;
            r_fwd_m   <= r_s1_px;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the window, pick neighbours, form the Laplacian
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_win_top  <= s1_a;
            r_win_mid1 <= r_win_mid2;
            r_win_mid2 <= s1_m;
            r_win_bot  <= r_s1_px;
        end
    end

    always_comb begin
        sel_c = r_win_mid2;
        sel_u = r_s1_ctl.top     ? sel_c : r_win_top;
        sel_d = r_s1_ctl.bot     ? sel_c : r_win_bot;
        sel_l = r_s1_ctl.lf_self ? sel_c : r_win_mid1;
        sel_r = r_s1_ctl.rt_self ? sel_c : s1_m;
        for (int k = 0; k < 3; k++) begin
            lap[k] = LAP_W'({sel_c[k], 2'b00}) - LAP_W'(sel_u[k]) - LAP_W'(sel_d[k])
                   - LAP_W'(sel_l[k]) - LAP_W'(sel_r[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctr  <= sel_c;
        r_s2_lap  <= lap;
        r_s2_rend <= r_s1_ctl.row_end;
        r_s2_fend <= r_s1_ctl.frame_end;
    end

    // ------------------------------------------------------------------
    // Stage 2: centre plus gain times Laplacian
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = signed'(V_W'({r_s2_ctr[k], F'(0)}))
                    + signed'(V_W'(r_gain)) * V_W'(r_s2_lap[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_v    <= prod;
        r_s3_rend <= r_s2_rend;
        r_s3_fend <= r_s2_fend;
    end

    // ------------------------------------------------------------------
    // Stage 3: round, saturate, queue
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res_in.px[k] = round_sat(r_s3_v[k]);
        end
        res_in.row_end   = r_s3_rend;
        res_in.frame_end = r_s3_fend;
    end

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_fifo[r_wr_ptr] <= res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s3_vld) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(r_s3_vld) - CNT_W'(pop);
        end
    end

    // Hold input while queued plus in-flight results leave no free slot
    assign committed = r_cnt + CNT_W'(r_s1_vld && r_s1_ctl.emit)
                     + CNT_W'(r_s2_vld) + CNT_W'(r_s3_vld);
    assign i_pix.ready = (committed < CNT_W'(lsh_pkg::FIFO_DEPTH));

    assign o_res.valid     = (r_cnt != '0);
    assign o_res.out_blue  = head.px[0];
    assign o_res.out_green = head.px[1];
    assign o_res.out_red   = head.px[2];
    assign o_res.row_end   = head.row_end;
    assign o_res.frame_end = head.frame_end;

endmodule

>>> design/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_checker - port-level checks for the sharpening filter
//
// Watches the pixel and result channels of the top level over time; bound
// to every instance of the filter.
// ----------------------------------------------------------------------------
module lsh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsh_pix_if.sink     i_pix,
    lsh_res_if.source   o_res
);

    // A stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=>
            $stable(o_res.out_blue) && $stable(o_res.out_green) && $stable(o_res.out_red)
            && $stable(o_res.row_end) && $stable(o_res.frame_end))
        else $error("result payload changed while stalled");

    // Input back-pressure only comes from results waiting downstream
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_res.valid)
        else $error("input held off with no result waiting");

    // Frame end marks the last pixel of a row as well
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.frame_end |-> o_res.row_end)
        else $error("frame end without row end");

    // Leaving reset: queue empty, input open
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_res.valid && i_pix.ready)
        else $error("pipeline not clear after reset");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pix   (i_pix),
    .o_res   (o_res)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for laplacian_sharpen_3x3
//
// Streams BGR frames and drain ticks into the filter under random idling on
// both channels and checks every sharpened pixel, with its row and frame end
// markers, against a cycle-free predictor of the line stores and the 3x3
// window. Geometry and gain are rewritten between phases while the filter is
// idle: reset values, clamped extremes, single-row frames, cut-short flushes,
// surplus drain ticks and frames abandoned part way through.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int IDLE_PCT       = 21;
    localparam int RANDOM_ITEMS   = 640;

    typedef struct packed {
        lsh_pkg::t_cmd              cmd;
        logic [lsh_pkg::CHAN_W-1:0] blue;
        logic [lsh_pkg::CHAN_W-1:0] green;
        logic [lsh_pkg::CHAN_W-1:0] red;
    } t_pix_txn;

    typedef struct packed {
        logic [lsh_pkg::CHAN_W-1:0] blue;
        logic [lsh_pkg::CHAN_W-1:0] green;
        logic [lsh_pkg::CHAN_W-1:0] red;
        logic                       row_end;
        logic                       frame_end;
    } t_sharp_px;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    lsh_pkg::t_cfg_idx              cfg_index = lsh_pkg::CFG_WIDTH;
    logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    lsh_pix_if pix_if ();
    lsh_res_if res_if ();

    laplacian_sharpen_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_res       (res_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_pix_txn    pending_q[$];
    t_sharp_px   sharp_q[$];
    bit          no_stall;
    int unsigned mismatch_cnt;
    int unsigned quiet_cycles;

    // Predictor state: two line stores, the 3x3 window, raster position
    logic [23:0]                    above_row [lsh_pkg::MAX_WIDTH];
    logic [23:0]                    mid_row   [lsh_pkg::MAX_WIDTH];
    logic [23:0]                    win [3][3];
    int unsigned                    col_pos, row_pos, drains_owed;
    logic [lsh_pkg::CFG_DATA_W-1:0] cur_width  = 12'd640;
    logic [lsh_pkg::CFG_DATA_W-1:0] cur_height = 12'd480;
    logic [lsh_pkg::GAIN_W-1:0]     cur_gain   = 10'd256;

    function automatic int unsigned clamp_geom(logic [lsh_pkg::CFG_DATA_W-1:0] v,
                                               int unsigned lim);
        if (v == 0) begin
            return 1;
        end
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [lsh_pkg::CHAN_W-1:0] sharpen_chan(int c, int u, int d,
                                                                int l, int r);
        longint lap, acc, q, rem, half;
        lap  = 4 * c - u - d - l - r;
        acc  = c * (longint'(1) << lsh_pkg::GAIN_FRAC_BITS) + longint'(cur_gain) * lap;
        half = longint'(1) << (lsh_pkg::GAIN_FRAC_BITS - 1);
        if (acc <= 0) begin
            return '0;
        end
        q   = acc >> lsh_pkg::GAIN_FRAC_BITS;
        rem = acc & ((longint'(1) << lsh_pkg::GAIN_FRAC_BITS) - 1);
        // round half to even
        if (rem > half || (rem == half && (q % 2) == 1)) begin
            q++;
        end
        return (q > 255) ? 8'd255 : lsh_pkg::CHAN_W'(q);
    endfunction

    // Sharpen the middle-row pixel at window column cc, lc/rc its neighbours
    function automatic t_sharp_px sharpen_at(int cc, int lc, int rc, int unsigned r,
                                             int unsigned c, int unsigned w, int unsigned h);
        logic [23:0] ctr, up, dn, lf, rt;
        t_sharp_px   px;
        ctr = win[1][cc];
        up  = (r == 0) ? ctr : win[0][cc];
        dn  = (r == h - 1) ? ctr : win[2][cc];
        lf  = win[1][lc];
        rt  = win[1][rc];
        px.blue      = sharpen_chan(ctr[7:0], up[7:0], dn[7:0], lf[7:0], rt[7:0]);
        px.green     = sharpen_chan(ctr[15:8], up[15:8], dn[15:8], lf[15:8], rt[15:8]);
        px.red       = sharpen_chan(ctr[23:16], up[23:16], dn[23:16], lf[23:16], rt[23:16]);
        px.row_end   = (c == w - 1);
        px.frame_end = (c == w - 1) && (r == h - 1);
        return px;
    endfunction

    // Shift raster column cc of row rr into the window, queue what falls due
    function automatic void shift_column(int unsigned rr, int unsigned cc, logic [23:0] px);
        int unsigned w, h;
        logic [23:0] a, m;
        w = clamp_geom(cur_width, lsh_pkg::MAX_WIDTH);
        h = clamp_geom(cur_height, lsh_pkg::MAX_HEIGHT);
        // last pixel of the row two above, its right neighbour replicated
        if (cc == 0 && rr >= 2) begin
            sharp_q.push_back(sharpen_at(2, (w == 1) ? 2 : 1, 2, rr - 2, w - 1, w, h));
        end
        a = above_row[cc];
        m = mid_row[cc];
        above_row[cc] = m;
        mid_row[cc]   = px;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = a;
        win[1][2] = m;
        win[2][2] = px;
        if (cc >= 1 && rr >= 1) begin
            sharp_q.push_back(sharpen_at(1, (cc == 1) ? 1 : 0, (cc == w) ? 1 : 2,
                                         rr - 1, cc - 1, w, h));
        end
    endfunction

    function automatic void predict_txn(t_pix_txn t);
        int unsigned w, h, d;
        w = clamp_geom(cur_width, lsh_pkg::MAX_WIDTH);
        h = clamp_geom(cur_height, lsh_pkg::MAX_HEIGHT);
        if (t.cmd == lsh_pkg::CMD_PIXEL) begin
            drains_owed = 0;
            if (col_pos >= w || row_pos >= h) begin
                col_pos = 0;
                row_pos = 0;
            end
            shift_column(row_pos, col_pos, {t.red, t.green, t.blue});
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos     = 0;
                    drains_owed = w + 1;
                end
            end
        end else if (drains_owed == 0 || drains_owed > w + 1) begin
            drains_owed = 0;
        end else begin
            d = w + 1 - drains_owed;
            if (d < w) begin
                shift_column(h, d, '0);
            end else begin
                shift_column(h + 1, 0, '0);
            end
            drains_owed--;
        end
    endfunction

    function automatic void predict_cfg(lsh_pkg::t_cfg_idx idx,
                                        logic [lsh_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsh_pkg::CFG_WIDTH, lsh_pkg::CFG_HEIGHT: begin
                if (idx == lsh_pkg::CFG_WIDTH) begin
                    cur_width = data;
                end else begin
                    cur_height = data;
                end
                col_pos     = 0;
                row_pos     = 0;
                drains_owed = 0;
            end
            lsh_pkg::CFG_GAIN: begin
                cur_gain = data[lsh_pkg::GAIN_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Input driver: hold a transaction until it is taken
    always @(posedge i_clk) begin : pix_driver
        t_pix_txn nxt;
        if (!i_rst_n) begin
            pix_if.valid    <= 1'b0;
            pix_if.cmd      <= lsh_pkg::CMD_PIXEL;
            pix_if.in_blue  <= '0;
            pix_if.in_green <= '0;
            pix_if.in_red   <= '0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pending_q.size() != 0 && (no_stall || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_q.pop_front();
                pix_if.valid    <= 1'b1;
                pix_if.cmd      <= nxt.cmd;
                pix_if.in_blue  <= nxt.blue;
                pix_if.in_green <= nxt.green;
                pix_if.in_red   <= nxt.red;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on each accepted transaction, check each result
    always @(posedge i_clk) begin : sharp_monitor
        t_sharp_px want, got;
        bit        moved;
        if (!i_rst_n) begin
            mismatch_cnt = 0;
            quiet_cycles = 0;
            col_pos      = 0;
            row_pos      = 0;
            drains_owed  = 0;
            for (int i = 0; i < lsh_pkg::MAX_WIDTH; i++) begin
                above_row[i] = '0;
                mid_row[i]   = '0;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win[i][j] = '0;
                end
            end
        end else begin
            moved = 1'b0;
            if (cfg_wr_en) begin
                predict_cfg(cfg_index, cfg_data);
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                got = '{res_if.out_blue, res_if.out_green, res_if.out_red,
                        res_if.row_end, res_if.frame_end};
                if (sharp_q.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("unexpected pixel b=%0d g=%0d r=%0d row_end=%b frame_end=%b",
                                 got.blue, got.green, got.red, got.row_end, got.frame_end);
                    end
                    mismatch_cnt++;
                end else begin
                    want = sharp_q.pop_front();
                    if (got !== want) begin
                        if (mismatch_cnt < 10) begin
                            $display("pixel mismatch: expected b=%0d g=%0d r=%0d re=%b fe=%b",
                                     want.blue, want.green, want.red, want.row_end,
                                     want.frame_end);
                            $display("                got      b=%0d g=%0d r=%0d re=%b fe=%b",
                                     got.blue, got.green, got.red, got.row_end,
                                     got.frame_end);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                moved = 1'b1;
                predict_txn('{lsh_pkg::t_cmd'(pix_if.cmd), pix_if.in_blue, pix_if.in_green,
                              pix_if.in_red});
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_px(logic [lsh_pkg::CHAN_W-1:0] b, logic [lsh_pkg::CHAN_W-1:0] g,
                           logic [lsh_pkg::CHAN_W-1:0] r);
        pending_q.push_back('{lsh_pkg::CMD_PIXEL, b, g, r});
    endtask

    task automatic push_drain();
        // pixel lanes are don't-care on a drain tick: randomise them
        pending_q.push_back('{lsh_pkg::CMD_DRAIN, lsh_pkg::CHAN_W'($urandom),
                              lsh_pkg::CHAN_W'($urandom), lsh_pkg::CHAN_W'($urandom)});
    endtask

    function automatic logic [lsh_pkg::CHAN_W-1:0] pick_chan(int style, int base);
        int v;
        case (style)
            0: v = $urandom_range(255);
            1: v = base + int'($urandom_range(16)) - 8;
            2: v = $urandom_range(1) ? 255 : 0;
            default: v = base;
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return lsh_pkg::CHAN_W'(v);
    endfunction

    // n_px raster pixels of one texture, then n_drain drain ticks
    task automatic push_frame(int unsigned n_px, int unsigned n_drain);
        int style, bb, gb, rb;
        style = $urandom_range(3);
        bb    = $urandom_range(255);
        gb    = $urandom_range(255);
        rb    = $urandom_range(255);
        repeat (n_px) begin
            push_px(pick_chan(style, bb), pick_chan(style, gb), pick_chan(style, rb));
        end
        repeat (n_drain) begin
            push_drain();
        end
    endtask

    // Wait for every transaction and result, then let the pipeline empty
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || pix_if.valid || sharp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(lsh_pkg::t_cfg_idx idx, logic [lsh_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : main
        int unsigned w, h, kind, cut, counted, phase;
        no_stall = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry: still inside the warm-up of a 640-wide frame
        push_frame(24, 0);
        settle();

        // 3x2 frame at reset gain, with a drain tick while nothing is owed
        cfg_write(lsh_pkg::CFG_WIDTH, 12'd3);
        cfg_write(lsh_pkg::CFG_HEIGHT, 12'd2);
        push_drain();
        push_px(8'h00, 8'hFF, 8'h55);
        push_px(8'hFF, 8'h00, 8'hAA);
        push_px(8'hAA, 8'h55, 8'hFF);
        push_px(8'h55, 8'hAA, 8'h00);
        push_px(8'hFF, 8'hFF, 8'hFF);
        push_px(8'h00, 8'h00, 8'h00);
        repeat (4) push_drain();
        settle();

        // Zero geometry acts as 1x1; top gain; first drain of a single row is silent
        cfg_write(lsh_pkg::CFG_WIDTH, '0);
        cfg_write(lsh_pkg::CFG_HEIGHT, '0);
        cfg_write(lsh_pkg::CFG_GAIN, 12'd1023);
        push_px(8'h80, 8'h01, 8'hFE);
        repeat (2) push_drain();
        settle();

        // Zero gain; cut the flush short with the next frame's first pixel
        cfg_write(lsh_pkg::CFG_WIDTH, 12'd2);
        cfg_write(lsh_pkg::CFG_HEIGHT, 12'd2);
        cfg_write(lsh_pkg::CFG_GAIN, '0);
        push_frame(4, 1);
        push_frame(4, 3);
        push_drain();
        settle();

        // Geometry above the limit: a short stretch inside the first row
        cfg_write(lsh_pkg::CFG_WIDTH, 12'hFFF);
        cfg_write(lsh_pkg::CFG_HEIGHT, 12'hFFF);
        push_frame(16, 0);
        settle();

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            // one long phase without any idling on either side
            no_stall = (phase == 1);
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            if (no_stall) begin
                w = 24;
                h = 6;
            end
            cfg_write(lsh_pkg::CFG_WIDTH,
                      (w == 1 && $urandom_range(1)) ? '0 : lsh_pkg::CFG_DATA_W'(w));
            cfg_write(lsh_pkg::CFG_HEIGHT,
                      (h == 1 && $urandom_range(1)) ? '0 : lsh_pkg::CFG_DATA_W'(h));
            if ($urandom_range(2) != 0) begin
                case ($urandom_range(4))
                    0: cfg_write(lsh_pkg::CFG_GAIN, '0);
                    1: cfg_write(lsh_pkg::CFG_GAIN, 12'd1023);
                    2: cfg_write(lsh_pkg::CFG_GAIN, 12'd256);
                    default: cfg_write(lsh_pkg::CFG_GAIN,
                                       lsh_pkg::CFG_DATA_W'($urandom_range(1023)));
                endcase
            end
            repeat ($urandom_range(3, 1)) begin
                kind = $urandom_range(99);
                if (kind < 75) begin
                    push_frame(w * h, w + 1);
                    counted += w * h + w + 1;
                end else if (kind < 85) begin
                    // flush cut short: next pixel starts a new frame
                    cut = $urandom_range(w);
                    push_frame(w * h, cut);
                    counted += w * h + cut;
                end else if (kind < 93) begin
                    // surplus drain ticks are ignored
                    push_frame(w * h, w + 1 + $urandom_range(3, 1));
                    counted += w * h + w + 1;
                end else begin
                    // abandon the frame part way through
                    cut = $urandom_range(w * h, 1);
                    push_frame(cut, 0);
                    counted += cut;
                end
            end
            settle();
            phase++;
        end

        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
